// ----- hw/rtl/aerd_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the address-event record decoder
// no dependencies; imported by every module of the block

package aerd_pkg;

	// record format codes (register record_format)
	typedef enum logic [1:0] {
		FMT_4B   = 2'd0,
		FMT_6B   = 2'd1,
		FMT_8B   = 2'd2,
		FMT_NONE = 2'd3
	} fmt_t;

	// register index on the configuration port
	typedef enum logic [1:0] {
		REG_FORMAT  = 2'd0,
		REG_CAMERA  = 2'd1,
		REG_BORDER_MIN = 2'd2,
		REG_BORDER_MAX = 2'd3
	} reg_idx_t;

	// what the back part does with a queued record
	typedef enum logic [1:0] {
		KIND_EVENT     = 2'd0,
		KIND_EVENT_OFS = 2'd1,
		KIND_WRAP      = 2'd2,
		KIND_CLEAR     = 2'd3
	} kind_t;

	localparam int unsigned COORD_W   = 7;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned POS_W     = 3;
	localparam int unsigned REC_DEPTH = 7;
	localparam int unsigned OUT_W     = 48;
	localparam int unsigned APB_AW    = 4;
	localparam int unsigned APB_DW    = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [POS_W-1:0] LAST_4B = 3'd3;
	localparam logic [POS_W-1:0] LAST_6B = 3'd5;
	localparam logic [POS_W-1:0] LAST_8B = 3'd7;

	localparam logic [TIME_W-1:0]  WRAP_STEP    = 32'h0000_4000;
	localparam logic [COORD_W-1:0] COORD_MAX    = 7'd127;
	localparam logic [COORD_W-1:0] BORDER_MIN_RST = 7'd5;
	localparam logic [COORD_W-1:0] BORDER_MAX_RST = 7'd122;

	// one decoded record between the front and back parts
	typedef struct packed {
		kind_t               kind;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic                pol;
		logic [TIME_W-1:0]   tstamp;
	} rec_t;

	localparam int unsigned REC_W = $bits(rec_t);

endpackage

// ----- hw/rtl/aerd_front.sv -----
`timescale 1ns / 1ps
// front part: byte alignment, record assembly and classification
// depends on aerd_pkg

module aerd_front import aerd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fmt_t              record_format,
	input  logic              camera_select,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // data_byte
	input  logic              s_tuser,   // buffer_start
	input  logic              q_full,
	output logic              push,
	output rec_t              push_rec
);

	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] rec_q [REC_DEPTH];
	logic [POS_W-1:0]  pos_eff;
	logic [POS_W-1:0]  last_pos;
	logic              fmt_ok;
	logic              accept;
	logic              is_last;
	logic              keep;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign pos_eff  = s_tuser ? '0 : pos_q;

	always_comb begin
		unique case (record_format)
			FMT_4B: begin
				last_pos = LAST_4B;
				fmt_ok   = 1'b1;
			end
			FMT_6B: begin
				last_pos = LAST_6B;
				fmt_ok   = 1'b1;
			end
			FMT_8B: begin
				last_pos = LAST_8B;
				fmt_ok   = 1'b1;
			end
			default: begin
				last_pos = '0;
				fmt_ok   = 1'b0;
			end
		endcase
	end

	assign is_last = fmt_ok && (pos_eff >= last_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (!fmt_ok || is_last) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_eff + POS_W'(1);
			end
		end
	end

	// record byte store, only written below the last position
	always_ff @(posedge clk) begin
		if (accept && fmt_ok && !is_last) begin
			rec_q[pos_eff] <= s_tdata;
		end
	end

	// decode with the incoming byte as the last one
	always_comb begin
		push_rec = '0;
		keep     = 1'b1;
		unique case (record_format)
			FMT_4B: begin
				push_rec.x      = rec_q[0][7:1];
				push_rec.pol    = rec_q[0][0];
				push_rec.y      = rec_q[1][6:0];
				push_rec.tstamp = {16'h0000, s_tdata, rec_q[2]};
				if (s_tdata[7]) begin
					push_rec.kind = KIND_WRAP;
				end else if (s_tdata[6]) begin
					push_rec.kind = KIND_CLEAR;
				end else begin
					push_rec.kind = KIND_EVENT_OFS;
				end
			end
			FMT_6B: begin
				push_rec.kind   = KIND_EVENT;
				push_rec.y      = rec_q[0][6:0];
				push_rec.x      = rec_q[1][7:1];
				push_rec.pol    = rec_q[1][0];
				push_rec.tstamp = {rec_q[2], rec_q[3], rec_q[4], s_tdata};
			end
			FMT_8B: begin
				push_rec.kind   = KIND_EVENT;
				keep            = (rec_q[2][7] == camera_select);
				push_rec.y      = COORD_MAX - rec_q[2][6:0];
				push_rec.x      = rec_q[3][7:1];
				push_rec.pol    = rec_q[3][0];
				push_rec.tstamp = {rec_q[4], rec_q[5], rec_q[6], s_tdata};
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = accept && is_last && keep;

endmodule

// ----- hw/rtl/aerd_fifo.sv -----
`timescale 1ns / 1ps
// short queue of decoded records between front and back parts
// depends on aerd_pkg

module aerd_fifo import aerd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output rec_t pop_rec
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/aerd_back.sv -----
`timescale 1ns / 1ps
// back part: wrap offset, window filter and output register
// depends on aerd_pkg

module aerd_back import aerd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COORD_W-1:0] border_min,
	input  logic [COORD_W-1:0] border_max,
	input  logic               q_valid,
	input  rec_t               q_rec,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata    // event_x, event_y, event_on, event_time
);

	logic [TIME_W-1:0]  offset_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic               pol_q;
	logic [TIME_W-1:0]  tstamp_q;
	logic               is_event;
	logic               in_win;
	logic [TIME_W-1:0]  tstamp_sum;

	assign pop = q_valid && (!out_valid_q || m_tready);

	assign is_event = (q_rec.kind == KIND_EVENT) || (q_rec.kind == KIND_EVENT_OFS);
	assign in_win   = (q_rec.x >= border_min) && (q_rec.y >= border_min) &&
	                  (q_rec.x <= border_max) && (q_rec.y <= border_max);
	assign tstamp_sum = (q_rec.kind == KIND_EVENT_OFS) ? q_rec.tstamp + offset_q
	                                                   : q_rec.tstamp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= is_event && in_win;
			unique case (q_rec.kind)
				KIND_WRAP:  offset_q <= offset_q + WRAP_STEP;
				KIND_CLEAR: offset_q <= '0;
				default: ;
			endcase
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q      <= q_rec.x;
			y_q      <= q_rec.y;
			pol_q    <= q_rec.pol;
			tstamp_q <= tstamp_sum;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, tstamp_q, pol_q, y_q, x_q};

endmodule

// ----- hw/rtl/address_event_record_decoder.sv -----
`timescale 1ns / 1ps
// address-event record decoder: one byte per cycle in unless the queue is full,
// at most one event per record out; a record's event goes through the record queue
// and the output register to m_tvalid; at most one event per 4 bytes
// the record queue (4 deep by default) stalls input only while output is held off
// reset: registers to defaults (format 4-byte, camera 0, window 5..122), byte
// position and wrap offset zero, queue and output empty; record bytes not cleared
// depends on aerd_pkg, aerd_front, aerd_fifo, aerd_back

module address_event_record_decoder import aerd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	// byte stream in
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] buffer_start
	// event stream out
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata    // [6:0] event_x, [13:7] event_y,
	                                     // [14] event_on, [46:15] event_time, [47] zero
);

	fmt_t               fmt_q;
	logic               camera_q;
	logic [COORD_W-1:0] border_min_q;
	logic [COORD_W-1:0] border_max_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	logic q_full;
	logic q_push;
	rec_t q_push_rec;
	logic q_pop;
	logic q_valid;
	rec_t q_pop_rec;

	// register file, word-addressed by paddr[3:2]
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q        <= FMT_4B;
			camera_q     <= 1'b0;
			border_min_q <= BORDER_MIN_RST;
			border_max_q <= BORDER_MAX_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_FORMAT:     fmt_q        <= fmt_t'(pwdata[1:0]);
				REG_CAMERA:     camera_q     <= pwdata[0];
				REG_BORDER_MIN: border_min_q <= pwdata[COORD_W-1:0];
				REG_BORDER_MAX: border_max_q <= pwdata[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (cfg_idx)
			REG_FORMAT:     prdata = APB_DW'(fmt_q);
			REG_CAMERA:     prdata = APB_DW'(camera_q);
			REG_BORDER_MIN: prdata = APB_DW'(border_min_q);
			REG_BORDER_MAX: prdata = APB_DW'(border_max_q);
			default:        prdata = '0;
		endcase
	end

	// front: aligns bytes into records, drops other-camera records in the 8-byte format
	aerd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.record_format (fmt_q),
		.camera_select (camera_q),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.q_full        (q_full),
		.push          (q_push),
		.push_rec      (q_push_rec)
	);

	// queue decouples a stalled output from the byte stream
	aerd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_rec  (q_push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_rec   (q_pop_rec)
	);

	// back: markers update the offset, events get filtered and registered
	aerd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.border_min (border_min_q),
		.border_max (border_max_q),
		.q_valid    (q_valid),
		.q_rec      (q_pop_rec),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
